// ===== rtl/core/sidac_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package sidac_pkg;

    // Default input width
    localparam int VALUE_BITS_DEFAULT = 32;

    // Number of decimal digits needed for a magnitude of at most 2**(bits-1),
    // from floor(bits * log10(2)) + 1
    localparam int LOG10_2_NUM = 30103;
    localparam int LOG10_2_DEN = 100000;

    localparam int BCD_DIGIT_BITS = 4;

    localparam logic [7:0] ASCII_MINUS = 8'h2D;
    localparam logic [7:0] ASCII_ZERO  = 8'h30;
    localparam logic [7:0] ASCII_NINE  = 8'h39;

    // Map a BCD digit to its ASCII character
    function automatic logic [7:0] ascii_digit(input logic [BCD_DIGIT_BITS-1:0] d);
        ascii_digit = ASCII_ZERO + {4'b0000, d};
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/signed_integer_to_decimal_ascii_core.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Channel  Dir  Handshake            Payload
// -------  ---  -------------------  ---------------------------------------
// in       in   in_valid / in_ready  value    (VALUE_BITS, signed)
// out      out  out_valid/ out_ready out_char (8), is_last (1)
//
// Operation: a request is taken while idle, then shift-add-3 over all VALUE_BITS
// input bits (one input bit per cycle into the BCD register), then a '-' for a
// negative value and the digit positions of the BCD register, top digit first;
// leading zeros are dropped with no character, and the last digit always goes out.
// Reset clears the state machine and the output valid; payload is not reset.
// A stall on out_ready holds the character in the output register and halts
// emission; a new request is taken once the last character is registered.

module signed_integer_to_decimal_ascii_core #(
    parameter int VALUE_BITS = sidac_pkg::VALUE_BITS_DEFAULT
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         in_valid,
    output logic                              in_ready,
    input  wire logic signed [VALUE_BITS-1:0] value,
    output logic                              out_valid,
    input  wire logic                         out_ready,
    output logic             [7:0]            out_char,
    output logic                              is_last
);

    import sidac_pkg::*;

    localparam int NUM_DIGITS = (VALUE_BITS * LOG10_2_NUM) / LOG10_2_DEN + 1;
    localparam int BCD_W      = BCD_DIGIT_BITS * NUM_DIGITS;
    localparam int BCNT_W     = $clog2(VALUE_BITS + 1);
    localparam int DCNT_W     = $clog2(NUM_DIGITS + 1);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_CONV = 3'b010,
        ST_EMIT = 3'b100
    } state_t;

    state_t                  state_reg, state_next;
    logic [VALUE_BITS-1:0]   mag_reg, mag_next;
    logic [BCD_W-1:0]        bcd_reg, bcd_next;
    logic [BCNT_W-1:0]       bcnt_reg, bcnt_next;
    logic [DCNT_W-1:0]       dleft_reg, dleft_next;
    logic                    sign_reg, sign_next;
    logic                    started_reg, started_next;
    logic                    out_valid_reg, out_valid_next;
    logic [7:0]              out_char_reg, out_char_next;
    logic                    is_last_reg, is_last_next;

    logic [VALUE_BITS-1:0]   value_u;
    logic [VALUE_BITS-1:0]   mag_in;
    logic [BCD_W-1:0]        bcd_adj;
    logic [BCD_DIGIT_BITS-1:0] top_digit;
    logic                    load_ok;
    logic                    last_digit;

    // Form the magnitude in an unsigned word: the most negative value maps
    // to 2**(VALUE_BITS-1) without overflow
    assign value_u = value;
    assign mag_in  = value_u[VALUE_BITS-1]
                   ? (~value_u + {{(VALUE_BITS-1){1'b0}}, 1'b1})
                   : value_u;

    // Add 3 to every BCD digit of 5 or more before the shift
    always_comb
    begin
        for (int i = 0; i < NUM_DIGITS; i++)
        begin
            if (bcd_reg[i*BCD_DIGIT_BITS +: BCD_DIGIT_BITS] >= 4'd5)
            begin
                bcd_adj[i*BCD_DIGIT_BITS +: BCD_DIGIT_BITS] =
                    bcd_reg[i*BCD_DIGIT_BITS +: BCD_DIGIT_BITS] + 4'd3;
            end
            else
            begin
                bcd_adj[i*BCD_DIGIT_BITS +: BCD_DIGIT_BITS] =
                    bcd_reg[i*BCD_DIGIT_BITS +: BCD_DIGIT_BITS];
            end
        end
    end

    assign top_digit  = bcd_reg[BCD_W-1 -: BCD_DIGIT_BITS];
    assign load_ok    = !out_valid_reg || out_ready;
    assign last_digit = (dleft_reg == DCNT_W'(1));

    always_comb
    begin
        state_next     = state_reg;
        mag_next       = mag_reg;
        bcd_next       = bcd_reg;
        bcnt_next      = bcnt_reg;
        dleft_next     = dleft_reg;
        sign_next      = sign_reg;
        started_next   = started_reg;
        out_char_next  = out_char_reg;
        is_last_next   = is_last_reg;
        out_valid_next = out_valid_reg && !out_ready;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    mag_next     = mag_in;
                    sign_next    = value_u[VALUE_BITS-1];
                    bcd_next     = '0;
                    bcnt_next    = BCNT_W'(VALUE_BITS);
                    started_next = 1'b0;
                    state_next   = ST_CONV;
                end
            end
            ST_CONV:
            begin
                // Shift one magnitude bit into the adjusted BCD register
                bcd_next  = {bcd_adj[BCD_W-2:0], mag_reg[VALUE_BITS-1]};
                mag_next  = {mag_reg[VALUE_BITS-2:0], 1'b0};
                bcnt_next = bcnt_reg - BCNT_W'(1);
                if (bcnt_reg == BCNT_W'(1))
                begin
                    dleft_next = DCNT_W'(NUM_DIGITS);
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (load_ok && sign_reg)
                begin
                    out_char_next  = ASCII_MINUS;
                    is_last_next   = 1'b0;
                    out_valid_next = 1'b1;
                    sign_next      = 1'b0;
                end
                else if (!started_reg && top_digit == '0 && !last_digit)
                begin
                    // Drop a leading zero
                    bcd_next   = {bcd_reg[BCD_W-BCD_DIGIT_BITS-1:0], {BCD_DIGIT_BITS{1'b0}}};
                    dleft_next = dleft_reg - DCNT_W'(1);
                end
                else if (load_ok)
                begin
                    out_char_next  = ascii_digit(top_digit);
                    is_last_next   = last_digit;
                    out_valid_next = 1'b1;
                    started_next   = 1'b1;
                    bcd_next   = {bcd_reg[BCD_W-BCD_DIGIT_BITS-1:0], {BCD_DIGIT_BITS{1'b0}}};
                    dleft_next = dleft_reg - DCNT_W'(1);
                    if (last_digit)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            bcnt_reg      <= '0;
            dleft_reg     <= '0;
            sign_reg      <= 1'b0;
            started_reg   <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            bcnt_reg      <= bcnt_next;
            dleft_reg     <= dleft_next;
            sign_reg      <= sign_next;
            started_reg   <= started_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mag_reg      <= mag_next;
        bcd_reg      <= bcd_next;
        out_char_reg <= out_char_next;
        is_last_reg  <= is_last_next;
    end

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;
    assign out_char  = out_char_reg;
    assign is_last   = is_last_reg;

endmodule

`default_nettype wire

// ===== rtl/core/sidac_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none

module sidac_checker (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       in_valid,
    input wire logic       in_ready,
    input wire logic       out_valid,
    input wire logic       out_ready,
    input wire logic [7:0] out_char,
    input wire logic       is_last
);

    import sidac_pkg::*;

    // Hold a stalled result
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_char) && $stable(is_last))
        else $error("stalled result changed");

    // Emit only a minus sign or a decimal digit
    a_char_set: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_char == ASCII_MINUS)
                   || ((out_char >= ASCII_ZERO) && (out_char <= ASCII_NINE)))
        else $error("result is not a sign or digit");

    // A sign never ends the text
    a_sign_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_char == ASCII_MINUS) |-> !is_last)
        else $error("sign flagged as last");

    // Drop ready while a request is converted
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("request taken while converting");

endmodule

bind signed_integer_to_decimal_ascii_core sidac_checker u_sidac_checker (.*);

`default_nettype wire
